@@ src/assert_macros.svh @@
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/i2a_pkg.sv @@
// Types, constants and helper functions of the integer to ASCII formatter.
`default_nettype none
package i2a_pkg;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic [4:0] total;
    } t_out;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        neg;
        logic        dec;
        logic [31:0] bin;
        logic [63:0] dig;
    } t_work;

    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_OCT  = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;
    localparam logic [2:0] CMD_PTR  = 3'd5;

    localparam int DAB_BITS   = 4;
    localparam int DAB_STAGES = 8;
    localparam int DEC_DIGITS = 10;
    localparam int NIBBLES    = 16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    function automatic logic bcd_ok(input logic [4*DEC_DIGITS-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < DEC_DIGITS; j++) begin
            if (b[4*j +: 4] > 4'd9) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else if (upper) begin
            c = CH_UA + {4'd0, d} - 8'd10;
        end else begin
            c = CH_LA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/i2a_front.sv @@
// Input stage: command decode, sign handling and digit packing.
`default_nettype none
`include "assert_macros.svh"
module i2a_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire i2a_pkg::t_in   i_data,
    output logic                o_stall,
    output logic                o_valid,
    output i2a_pkg::t_work      o_work,
    input  wire logic           i_stall
);

    logic           r_valid;
    i2a_pkg::t_work r_work;
    logic           n_valid;
    i2a_pkg::t_work n_work;
    logic           ready;
    logic [31:0]    low;
    logic [32:0]    ext;

    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        low            = i_data.value[31:0];
        ext            = {1'b0, low};
        n_valid        = i_valid && (i_data.command <= i2a_pkg::CMD_PTR);
        n_work         = '0;
        n_work.cmd     = i_data.command;
        n_work.neg     = (i_data.command == i2a_pkg::CMD_SDEC) && low[31];
        n_work.dec     = (i_data.command == i2a_pkg::CMD_SDEC) ||
                         (i_data.command == i2a_pkg::CMD_UDEC);
        n_work.bin     = n_work.neg ? (~low) + 32'd1 : low;
        case (i_data.command)
            i2a_pkg::CMD_OCT: begin
                for (int i = 0; i < 11; i++) begin
                    n_work.dig[4*i +: 4] = {1'b0, ext[3*i +: 3]};
                end
            end
            i2a_pkg::CMD_HEXL, i2a_pkg::CMD_HEXU: begin
                n_work.dig = {32'd0, low};
            end
            i2a_pkg::CMD_PTR: begin
                n_work.dig = i_data.value;
            end
            default: begin
                n_work.dig = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready) begin
            r_work <= n_work;
        end
    end

    `CHK_NEXT(a_drop_bad_cmd, i_valid && !o_stall && (i_data.command > i2a_pkg::CMD_PTR), !r_valid, "unused command entered pipeline")

endmodule
`default_nettype wire

@@ src/i2a_dabble.sv @@
// One shift-and-add-3 stage of the binary to BCD converter.
`default_nettype none
`include "assert_macros.svh"
module i2a_dabble (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire i2a_pkg::t_work i_work,
    output logic                o_stall,
    output logic                o_valid,
    output i2a_pkg::t_work      o_work,
    input  wire logic           i_stall
);

    logic           r_valid;
    i2a_pkg::t_work r_work;
    i2a_pkg::t_work n_work;
    logic           ready;
    logic [4*i2a_pkg::DEC_DIGITS-1:0] bcd;
    logic [31:0]    bin;

    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        n_work = i_work;
        bcd    = i_work.dig[4*i2a_pkg::DEC_DIGITS-1:0];
        bin    = i_work.bin;
        for (int s = 0; s < i2a_pkg::DAB_BITS; s++) begin
            for (int j = 0; j < i2a_pkg::DEC_DIGITS; j++) begin
                if (bcd[4*j +: 4] >= 4'd5) bcd[4*j +: 4] = bcd[4*j +: 4] + 4'd3;
            end
            bcd = {bcd[4*i2a_pkg::DEC_DIGITS-2:0], bin[31]};
            bin = {bin[30:0], 1'b0};
        end
        if (i_work.dec) begin
            n_work.dig = {24'd0, bcd};
            n_work.bin = bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready) begin
            r_work <= n_work;
        end
    end

    `CHK_IMPLY(a_bcd_digits, r_valid && r_work.dec, i2a_pkg::bcd_ok(r_work.dig[39:0]), "BCD digit above nine")

endmodule
`default_nettype wire

@@ src/i2a_emit.sv @@
// Character serializer with registered output.
`default_nettype none
`include "assert_macros.svh"
module i2a_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire i2a_pkg::t_work i_work,
    output logic                o_stall,
    output logic                o_valid,
    output i2a_pkg::t_out       o_data,
    input  wire logic           i_stall
);

    logic                r_busy;
    logic [2:0]          r_cmd;
    logic [15:0][3:0]    r_dig;
    logic [4:0]          r_nd;
    logic [1:0]          r_pl;
    logic [4:0]          r_len;
    logic [4:0]          r_pos;
    logic                r_ovalid;
    i2a_pkg::t_out       r_out;

    logic [4:0]          n_nd;
    logic [1:0]          n_pl;
    i2a_pkg::t_out       n_out;
    logic                load;
    logic                out_en;
    logic                is_last;
    logic [4:0]          di;
    logic [3:0]          digit;

    assign o_stall = r_busy;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign load    = i_valid && !r_busy;
    assign out_en  = !r_ovalid || !i_stall;
    assign is_last = (r_pos == r_len - 5'd1);

    always_comb begin
        n_nd = 5'd1;
        for (int i = 0; i < i2a_pkg::NIBBLES; i++) begin
            if (i_work.dig[4*i +: 4] != 4'd0) n_nd = 5'(i + 1);
        end
        if (i_work.neg) begin
            n_pl = 2'd1;
        end else if (i_work.cmd == i2a_pkg::CMD_PTR) begin
            n_pl = 2'd2;
        end else begin
            n_pl = 2'd0;
        end
    end

    always_comb begin
        di    = r_nd - 5'd1 - (r_pos - {3'd0, r_pl});
        digit = r_dig[di[3:0]];
        n_out = '0;
        if (r_pos < {3'd0, r_pl}) begin
            if (r_cmd == i2a_pkg::CMD_PTR) begin
                n_out.character = (r_pos == 5'd0) ? i2a_pkg::CH_ZERO : i2a_pkg::CH_X;
            end else begin
                n_out.character = i2a_pkg::CH_MINUS;
            end
        end else begin
            n_out.character = i2a_pkg::hex_char(digit, r_cmd == i2a_pkg::CMD_HEXU);
        end
        n_out.last  = is_last;
        n_out.total = is_last ? r_len : 5'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pos    <= 5'd0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= 5'd0;
            end else if (r_busy && out_en) begin
                r_pos <= r_pos + 5'd1;
                if (is_last) r_busy <= 1'b0;
            end
            if (out_en) r_ovalid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_work.cmd;
            r_dig <= i_work.dig;
            r_nd  <= n_nd;
            r_pl  <= n_pl;
            r_len <= n_nd + {3'd0, n_pl};
        end
        if (r_busy && out_en) begin
            r_out <= n_out;
        end
    end

    `CHK_IMPLY(a_pos_in_range, r_busy, r_pos < r_len, "character index past text length")
    `CHK_IMPLY(a_total_range, r_ovalid && r_out.last, (r_out.total >= 5'd1) && (r_out.total <= 5'd18), "total out of range on last")

endmodule
`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// Top level of the integer to ASCII formatter.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------
//  input    | in  | i_valid / o_stall  | i_data (command, value)
//  output   | out | o_valid / i_stall  | o_data (character, last, total)
//
// The first character reaches o_data through the front stage register, the 8 BCD
// stages, the serializer load and the output register, in that order.
// While i_stall is low the serializer emits one character per cycle; it accepts the
// next item only after the last character of the current one. Reset is synchronous
// and clears all valid and busy flags. A stall holds every stage; nothing is lost.
`default_nettype none
module integer_to_ascii_formatter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire i2a_pkg::t_in  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output i2a_pkg::t_out      o_data,
    input  wire logic          i_stall
);

    i2a_pkg::t_work w_work  [0:i2a_pkg::DAB_STAGES];
    logic           w_valid [0:i2a_pkg::DAB_STAGES];
    logic           w_stall [0:i2a_pkg::DAB_STAGES];

    i2a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (w_valid[0]),
        .o_work  (w_work[0]),
        .i_stall (w_stall[0])
    );

    for (genvar g = 0; g < i2a_pkg::DAB_STAGES; g++) begin : g_dab
        i2a_dabble u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_work  (w_work[g]),
            .o_stall (w_stall[g]),
            .o_valid (w_valid[g+1]),
            .o_work  (w_work[g+1]),
            .i_stall (w_stall[g+1])
        );
    end

    i2a_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[i2a_pkg::DAB_STAGES]),
        .i_work  (w_work[i2a_pkg::DAB_STAGES]),
        .o_stall (w_stall[i2a_pkg::DAB_STAGES]),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
`default_nettype wire
